// ===== src/lkvc_pkg.sv =====
// Package with constants and types shared by the LRU key/value cache.
package lkvc_pkg;

   localparam int unsigned Capacity = 16;
   localparam int unsigned IdxW = $clog2(Capacity);
   localparam int unsigned CntW = $clog2(Capacity + 1);
   localparam logic [6:0] PercentScale = 7'd100;
   localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
   localparam logic [4:0] MaxEntriesReset = 5'd16;
   localparam int unsigned EntryW = 64 + 64 + 32;

   typedef enum logic [1:0] {
      OP_PUT = 2'd0,
      OP_GET = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_REQ,
      ST_SCAN,
      ST_EVICT_REQ,
      ST_EVICT,
      ST_FIND_REQ,
      ST_FIND,
      ST_WRITE,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== src/lru_key_value_cache.sv =====
// Fully associative LRU key/value cache with one entry memory and a serial divider.
// A clear or unused opcode goes straight to the divide; a get, or a put without eviction, first scans
// for the key, and a put that evicts scans for the oldest entry before that: each scan reads 16 entries.
// Every request ends with the divide; a new request is accepted only once the last one is done.
// The result appears for one cycle on rsp_valid; the receiver cannot stall.
// Reset empties the cache, clears counters and stamp, and sets max_entries to 16.
module lru_key_value_cache
   import lkvc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_key,
   input  logic [63:0] req_write_value,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [63:0] rsp_read_value,
   output logic [6:0]  rsp_hit_rate_percent,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_max_entries
);

   state_type state_ff, state_in;
   logic [4:0] max_ff;
   logic [Capacity-1:0] valid_ff, valid_in;
   logic [31:0] stamp_ff, stamp_in, hits_ff, hits_in, miss_ff, miss_in;
   op_type op_ff;
   logic [63:0] key_ff, wval_ff;
   logic [IdxW:0] idx_ff, idx_in;
   logic [IdxW-1:0] pick_ff, pick_in, slot_ff, slot_in;
   logic pick_ok_ff, pick_ok_in, found_ff, found_in;
   logic [31:0] age_ff, age_in;
   logic hit_ff, hit_in;
   logic [63:0] rval_ff, rval_in;
   logic [38:0] num_ff, num_in;
   logic [32:0] den_ff, den_in;
   logic [33:0] rem_ff, rem_in;
   logic [6:0] quo_ff, quo_in;
   logic [5:0] step_ff, step_in;

   logic mem_we;
   logic [IdxW-1:0] mem_addr;
   logic [EntryW-1:0] mem_wdata, mem_rdata;
   logic [63:0] rd_key, rd_val;
   logic [31:0] rd_stamp, rd_age;
   logic [IdxW-1:0] rd_idx;
   logic [CntW-1:0] occ;
   logic [CntW-1:0] limit;
   logic [IdxW-1:0] free_idx;
   logic free_ok;
   logic [33:0] rem_sh;

   lkvc_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .addr   (mem_addr),
      .wr_data(mem_wdata),
      .rd_data(mem_rdata)
   );

   assign rd_key = mem_rdata[159:96];
   assign rd_val = mem_rdata[95:32];
   assign rd_stamp = mem_rdata[31:0];
   assign rd_age = stamp_ff - rd_stamp;
   assign rd_idx = IdxW'(idx_ff - 1'b1);
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;

   always_comb begin
      occ = '0;
      free_ok = 1'b0;
      free_idx = '0;
      for (int i = Capacity - 1; i >= 0; i--) begin
         occ = occ + CntW'(valid_ff[i]);
         if (!valid_ff[i]) begin
            free_ok = 1'b1;
            free_idx = IdxW'(i);
         end
      end
      if (32'(max_ff) < 32'(Capacity)) begin
         limit = CntW'(max_ff);
      end else begin
         limit = CntW'(Capacity);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (op_type'(req_opcode))
                  OP_PUT: state_in = (occ >= limit) ? ST_SCAN_REQ : ST_FIND_REQ;
                  OP_GET: state_in = ST_FIND_REQ;
                  default: state_in = ST_DIV;
               endcase
            end
         end
         ST_SCAN_REQ: state_in = ST_SCAN;
         ST_SCAN: begin
            if (idx_ff == (IdxW + 1)'(Capacity)) state_in = ST_EVICT;
         end
         ST_EVICT: state_in = ST_FIND_REQ;
         ST_FIND_REQ: state_in = ST_FIND;
         ST_FIND: begin
            if (idx_ff == (IdxW + 1)'(Capacity)) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == 6'd39) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      stamp_in = stamp_ff;
      hits_in = hits_ff;
      miss_in = miss_ff;
      idx_in = idx_ff;
      pick_in = pick_ff;
      pick_ok_in = pick_ok_ff;
      age_in = age_ff;
      slot_in = slot_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      rval_in = rval_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      mem_we = 1'b0;
      mem_addr = IdxW'(idx_ff);
      mem_wdata = {key_ff, wval_ff, stamp_ff};
      rem_sh = '0;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            pick_ok_in = 1'b0;
            found_in = 1'b0;
            hit_in = 1'b0;
            rval_in = '0;
            step_in = '0;
            if (start && op_type'(req_opcode) == OP_CLEAR) begin
               valid_in = '0;
               hits_in = '0;
               miss_in = '0;
            end
         end
         ST_SCAN_REQ, ST_FIND_REQ: begin
            mem_addr = '0;
            idx_in = (IdxW + 1)'(1);
            pick_ok_in = (state_ff == ST_FIND_REQ) ? pick_ok_ff : 1'b0;
            found_in = 1'b0;
         end
         ST_SCAN: begin
            mem_addr = IdxW'(idx_ff);
            idx_in = idx_ff + 1'b1;
            if (valid_ff[rd_idx] && (!pick_ok_ff || rd_age > age_ff)) begin
               pick_ok_in = 1'b1;
               pick_in = rd_idx;
               age_in = rd_age;
            end
         end
         ST_EVICT: begin
            if (pick_ok_ff) valid_in[pick_ff] = 1'b0;
         end
         ST_FIND: begin
            mem_addr = IdxW'(idx_ff);
            idx_in = idx_ff + 1'b1;
            if (!found_ff && valid_ff[rd_idx] && rd_key == key_ff) begin
               found_in = 1'b1;
               slot_in = rd_idx;
               rval_in = rd_val;
            end
         end
         ST_WRITE: begin
            if (op_ff == OP_PUT) begin
               rval_in = '0;
               if (found_ff || free_ok) begin
                  mem_addr = found_ff ? slot_ff : free_idx;
                  mem_we = 1'b1;
                  valid_in[mem_addr] = 1'b1;
                  stamp_in = stamp_ff + 32'd1;
               end
            end else if (found_ff) begin
               hit_in = 1'b1;
               mem_addr = slot_ff;
               mem_we = 1'b1;
               mem_wdata = {key_ff, rval_ff, stamp_ff};
               stamp_in = stamp_ff + 32'd1;
               if (hits_ff != CountMax) hits_in = hits_ff + 32'd1;
            end else begin
               rval_in = '0;
               if (miss_ff != CountMax) miss_in = miss_ff + 32'd1;
            end
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               num_in = ({7'd0, hits_ff} << 6) + ({7'd0, hits_ff} << 5)
                        + ({7'd0, hits_ff} << 2);
               den_in = {1'b0, hits_ff} + {1'b0, miss_ff};
               rem_in = '0;
               quo_in = '0;
               step_in = 6'd1;
            end else begin
               rem_sh = {rem_ff[32:0], num_ff[38]};
               num_in = {num_ff[37:0], 1'b0};
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_in = rem_sh - {1'b0, den_ff};
                  quo_in = {quo_ff[5:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[5:0], 1'b0};
               end
               step_in = step_ff + 6'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_ff <= MaxEntriesReset;
         valid_ff <= '0;
         stamp_ff <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         stamp_ff <= stamp_in;
         hits_ff <= hits_in;
         miss_ff <= miss_in;
         if (csr_valid && csr_ready) max_ff <= csr_max_entries;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         op_ff <= op_type'(req_opcode);
         key_ff <= req_key;
         wval_ff <= req_write_value;
      end
      idx_ff <= idx_in;
      pick_ff <= pick_in;
      pick_ok_ff <= pick_ok_in;
      age_ff <= age_in;
      slot_ff <= slot_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      rval_ff <= rval_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
   end

   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_hit = hit_ff;
   assign rsp_read_value = hit_ff ? rval_ff : 64'd0;
   assign rsp_hit_rate_percent = (den_ff == '0) ? 7'd0 : quo_ff;

endmodule

// ===== src/lkvc_ram.sv =====
// Generic single-port RAM with a registered read.
module lkvc_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ===== tb/lru_key_value_cache_tb.sv =====
// Self-checking testbench for the LRU key/value cache with directed and random requests.
`timescale 1ns / 1ps

module lru_key_value_cache_tb
   import lkvc_pkg::*;
();

   localparam int unsigned Slots = Capacity;
   localparam int unsigned StallLimit = 5000;

   typedef struct packed {
      logic        hit;
      logic [63:0] read_value;
      logic [6:0]  rate;
   } lookup_result_type;

   typedef struct {
      op_type      op;
      logic [63:0] key;
      logic [63:0] wval;
      logic        fixed;
      lookup_result_type res;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [63:0] req_key;
   logic [63:0] req_write_value;
   logic        rsp_valid;
   logic        rsp_hit;
   logic [63:0] rsp_read_value;
   logic [6:0]  rsp_hit_rate_percent;
   logic        csr_valid;
   logic        csr_ready;
   logic [4:0]  csr_max_entries;

   logic        m_valid [Slots];
   logic [63:0] m_key [Slots];
   logic [63:0] m_value [Slots];
   logic [31:0] m_stamp [Slots];
   logic [31:0] m_clock;
   logic [31:0] m_hits;
   logic [31:0] m_misses;
   logic [4:0]  m_limit;

   lookup_result_type pending_results[$];
   int unsigned  errors;
   int unsigned  quiet_cycles;
   bit           quiet_mode;
   stim_row_type rows[$];

   lru_key_value_cache i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_key(req_key), .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_read_value(rsp_read_value),
      .rsp_hit_rate_percent(rsp_hit_rate_percent),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_max_entries(csr_max_entries)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [6:0] current_rate();
      logic [63:0] total;
      total = 64'(m_hits) + 64'(m_misses);
      if (total == 0) return 7'd0;
      return 7'((64'(m_hits) * 64'(PercentScale)) / total);
   endfunction

   function automatic lookup_result_type apply_lookup(op_type op, logic [63:0] key,
                                                      logic [63:0] wval);
      lookup_result_type r;
      int unsigned  limit, used, pick, slot;
      logic [31:0]  age, best;
      r = '0;
      slot = Slots;
      if (op == OP_PUT) begin
         limit = (m_limit < Slots) ? m_limit : Slots;
         used = 0;
         for (int i = 0; i < Slots; i++) used += m_valid[i];
         if (used >= limit) begin
            pick = Slots;
            best = 0;
            for (int i = 0; i < Slots; i++) begin
               age = m_clock - m_stamp[i];
               if (m_valid[i] && (pick == Slots || age > best)) begin
                  pick = i;
                  best = age;
               end
            end
            if (pick < Slots) m_valid[pick] = 1'b0;
         end
         for (int i = Slots - 1; i >= 0; i--)
            if (m_valid[i] && m_key[i] == key) slot = i;
         if (slot == Slots)
            for (int i = Slots - 1; i >= 0; i--)
               if (!m_valid[i]) slot = i;
         if (slot < Slots) begin
            m_valid[slot] = 1'b1;
            m_key[slot] = key;
            m_value[slot] = wval;
            m_stamp[slot] = m_clock;
            m_clock++;
         end
      end else if (op == OP_GET) begin
         for (int i = Slots - 1; i >= 0; i--)
            if (m_valid[i] && m_key[i] == key) slot = i;
         if (slot < Slots) begin
            r.hit = 1'b1;
            r.read_value = m_value[slot];
            m_stamp[slot] = m_clock;
            m_clock++;
            if (m_hits != CountMax) m_hits++;
         end else if (m_misses != CountMax) begin
            m_misses++;
         end
      end else if (op == OP_CLEAR) begin
         for (int i = 0; i < Slots; i++) m_valid[i] = 1'b0;
         m_hits = 0;
         m_misses = 0;
      end
      r.rate = current_rate();
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_hit), 64'd0);
         end else begin
            lookup_result_type w;
            w = pending_results.pop_front();
            if (rsp_hit !== w.hit) report_mismatch("hit", 64'(rsp_hit), 64'(w.hit));
            if (rsp_read_value !== w.read_value)
               report_mismatch("read_value", rsp_read_value, w.read_value);
            if (rsp_hit_rate_percent !== w.rate)
               report_mismatch("hit_rate", 64'(rsp_hit_rate_percent), 64'(w.rate));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic write_limit(logic [4:0] value);
      csr_valid <= 1'b1;
      csr_max_entries <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      m_limit = value;
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic send_request(op_type op, logic [63:0] key, logic [63:0] wval,
                               logic fixed, lookup_result_type fixed_res);
      lookup_result_type r;
      if (!quiet_mode)
         while ($urandom_range(99) < 18) @(posedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_key <= key;
      req_write_value <= wval;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      r = apply_lookup(op, key, wval);
      pending_results = {pending_results, (fixed ? fixed_res : r)};
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_key();
      case ($urandom_range(3))
         0: return {$urandom, $urandom};
         1: return 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(15));
         default: return 64'($urandom_range(23));
      endcase
   endfunction

   function automatic void add_row(op_type op, logic [63:0] key, logic [63:0] wval,
                                   logic fixed, lookup_result_type res);
      stim_row_type s;
      s.op = op; s.key = key; s.wval = wval; s.fixed = fixed; s.res = res;
      rows = {rows, s};
   endfunction

   initial begin
      lookup_result_type none;
      logic [4:0]   limits[6];
      op_type       op;
      none = '0;
      limits = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd7};
      errors = 0;
      quiet_mode = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_opcode <= OP_PUT;
      req_key <= '0;
      req_write_value <= '0;
      csr_valid <= 1'b0;
      csr_max_entries <= MaxEntriesReset;
      for (int i = 0; i < Slots; i++) begin
         m_valid[i] = 0; m_key[i] = 0; m_value[i] = 0; m_stamp[i] = 0;
      end
      m_clock = 0; m_hits = 0; m_misses = 0; m_limit = MaxEntriesReset;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(OP_GET, 64'd5, 64'd0, 1, none);
      add_row(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, none);
      add_row(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, none);
      add_row(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
              1, '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd50});
      add_row(OP_PUT, 64'd0, 64'd0, 0, none);
      add_row(OP_GET, 64'd0, 64'd0, 0, none);
      add_row(OP_PUT, 64'd0, 64'hA5A5_5A5A_0F0F_F0F0, 0, none);
      add_row(OP_GET, 64'd0, 64'd0, 0, none);
      add_row(OP_NONE, 64'd0, 64'd0, 0, none);
      add_row(OP_CLEAR, 64'd0, 64'd0, 1, none);
      add_row(OP_GET, 64'd0, 64'd0, 1, none);
      foreach (rows[i]) send_request(rows[i].op, rows[i].key, rows[i].wval,
                                     rows[i].fixed, rows[i].res);
      drain();

      foreach (limits[p]) begin
         write_limit(limits[p]);
         for (int n = 0; n < 100; n++) begin
            quiet_mode = (p == 4) && (n >= 30) && (n < 80);
            case ($urandom_range(19))
               0: op = OP_CLEAR;
               1: op = OP_NONE;
               2, 3, 4, 5, 6, 7, 8, 9: op = OP_PUT;
               default: op = OP_GET;
            endcase
            send_request(op, pick_key(), {$urandom, $urandom}, 0, none);
            if (n == 50) while (pending_results.size() != 0) @(posedge clock);
         end
         drain();
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
